>>> rtl/rfd_pkg.sv
// Shared constants and controller/datapath interface types for the frame deframer.
package rfd_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CMP_W     = 10;

    localparam logic [7:0] TAIL_FILL = 8'hFF;
    localparam logic [7:0] MIN_LEN   = 8'd2;
    localparam logic [7:0] TAIL_LEN  = 8'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_NET_ID   = 3'd0;
    localparam logic [2:0] REG_START    = 3'd1;
    localparam logic [2:0] REG_END      = 3'd2;
    localparam logic [2:0] REG_PROTOCOL = 3'd3;
    localparam logic [2:0] REG_CODE_A   = 3'd4;
    localparam logic [2:0] REG_CODE_B   = 3'd5;
    localparam logic [2:0] REG_CODE_C   = 3'd6;
    localparam logic [2:0] REG_CODE_D   = 3'd7;

    typedef struct packed {
        logic load_len;
        logic write_body;
        logic rd_en;
    } t_cmd;

    typedef struct packed {
        logic start_match;
        logic net_hi_match;
        logic net_lo_match;
        logic len_ok;
        logic body_last;
        logic frame_good;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

>>> rtl/rfd_ctrl.sv
// Frame deframer controller: header hunt, body collection and drain sequencing.
module rfd_ctrl
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_NET_HI,
        S_NET_LO,
        S_LEN,
        S_BODY,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_stall = (r_state == S_DRAIN);
    assign w_acc      = i_in_valid && (r_state != S_DRAIN);

    always_comb begin
        n_state          = r_state;
        o_cmd.load_len   = 1'b0;
        o_cmd.write_body = 1'b0;
        o_cmd.rd_en      = 1'b0;
        case (r_state)
            S_HUNT: begin
                if (w_acc && i_status.start_match) begin
                    n_state = S_NET_HI;
                end
            end
            S_NET_HI: begin
                if (w_acc) begin
                    if (i_status.net_hi_match) begin
                        n_state = S_NET_LO;
                    end else begin
                        n_state = i_status.start_match ? S_NET_HI : S_HUNT;
                    end
                end
            end
            S_NET_LO: begin
                if (w_acc) begin
                    if (i_status.net_lo_match) begin
                        n_state = S_LEN;
                    end else begin
                        n_state = i_status.start_match ? S_NET_HI : S_HUNT;
                    end
                end
            end
            S_LEN: begin
                if (w_acc) begin
                    o_cmd.load_len = 1'b1;
                    n_state = i_status.len_ok ? S_BODY : S_HUNT;
                end
            end
            S_BODY: begin
                if (w_acc) begin
                    o_cmd.write_body = 1'b1;
                    if (i_status.body_last) begin
                        n_state = i_status.frame_good ? S_DRAIN : S_HUNT;
                    end
                end
            end
            S_DRAIN: begin
                // advance one word whenever the output register frees up
                o_cmd.rd_en = i_status.out_free;
                if (i_status.out_free && i_status.rd_last) begin
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/rfd_datapath.sv
// Frame deframer datapath: config registers, byte compares, body store and output register.
module rfd_datapath
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [7:0]  i_rx_byte,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_command,
    output logic        o_last_byte
);

    logic [15:0]       r_net_id;
    logic [7:0]        r_start;
    logic [7:0]        r_end;
    logic [7:0]        r_protocol;
    logic [7:0]        r_code_a;
    logic [7:0]        r_code_b;
    logic [7:0]        r_code_c;
    logic [7:0]        r_code_d;

    logic [7:0]        r_len;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_rd;
    logic              r_proto_ok;
    logic              r_code_ok;
    logic              r_ff1_ok;
    logic              r_ff2_ok;

    logic [7:0]        r_mem [MAX_FRAME];
    logic [7:0]        r_rd_data;
    logic              r_is_cmd;
    logic              r_last;
    logic              r_out_valid;

    logic [CMP_W-1:0]  w_cnt_x;
    logic [CMP_W-1:0]  w_rd_x;
    logic [CMP_W-1:0]  w_len_x;
    logic [CMP_W-1:0]  w_rx_x;
    logic              w_code_hit;

    assign w_cnt_x = CMP_W'(r_cnt);
    assign w_rd_x  = CMP_W'(r_rd);
    assign w_len_x = CMP_W'(r_len);
    assign w_rx_x  = CMP_W'(i_rx_byte);

    assign w_code_hit = (i_rx_byte == r_code_a) || (i_rx_byte == r_code_b) ||
                        (i_rx_byte == r_code_c) || (i_rx_byte == r_code_d);

    always_comb begin
        o_status.start_match  = (i_rx_byte == r_start);
        o_status.net_hi_match = (i_rx_byte == r_net_id[15:8]);
        o_status.net_lo_match = (i_rx_byte == r_net_id[7:0]);
        o_status.len_ok       = (i_rx_byte >= MIN_LEN) &&
                                (w_rx_x + CMP_W'(TAIL_LEN) <= CMP_W'(MAX_FRAME));
        o_status.body_last    = (w_cnt_x == w_len_x + CMP_W'(MIN_LEN));
        o_status.frame_good   = r_proto_ok && r_code_ok && r_ff1_ok && r_ff2_ok &&
                                (i_rx_byte == r_end);
        o_status.rd_last      = (w_rd_x == w_len_x - CMP_W'(1));
        o_status.out_free     = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_id   <= 16'd0;
            r_start    <= 8'd2;
            r_end      <= 8'd3;
            r_protocol <= 8'd0;
            r_code_a   <= 8'd0;
            r_code_b   <= 8'd0;
            r_code_c   <= 8'd0;
            r_code_d   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NET_ID:   r_net_id   <= i_cfg_data;
                REG_START:    r_start    <= i_cfg_data[7:0];
                REG_END:      r_end      <= i_cfg_data[7:0];
                REG_PROTOCOL: r_protocol <= i_cfg_data[7:0];
                REG_CODE_A:   r_code_a   <= i_cfg_data[7:0];
                REG_CODE_B:   r_code_b   <= i_cfg_data[7:0];
                REG_CODE_C:   r_code_c   <= i_cfg_data[7:0];
                REG_CODE_D:   r_code_d   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 8'd0;
            r_cnt <= '0;
            r_rd  <= '0;
        end else begin
            if (i_cmd.load_len) begin
                r_len <= i_rx_byte;
                r_cnt <= '0;
                r_rd  <= ADDR_W'(1);
            end
            if (i_cmd.write_body) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
            if (i_cmd.rd_en) begin
                r_rd <= r_rd + ADDR_W'(1);
            end
        end
    end

    // store the body and check protocol, command and tail as it streams in
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_body) begin
            r_mem[r_cnt] <= i_rx_byte;
            if (w_cnt_x == CMP_W'(0)) begin
                r_proto_ok <= (i_rx_byte == r_protocol);
            end
            if (w_cnt_x == CMP_W'(1)) begin
                r_code_ok <= w_code_hit;
            end
            if (w_cnt_x == w_len_x) begin
                r_ff1_ok <= (i_rx_byte == TAIL_FILL);
            end
            if (w_cnt_x == w_len_x + CMP_W'(1)) begin
                r_ff2_ok <= (i_rx_byte == TAIL_FILL);
            end
        end
    end

    // memory read register doubles as the output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd];
            r_is_cmd  <= (w_rd_x == CMP_W'(1));
            r_last    <= o_status.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_rd_data;
    assign o_is_command   = r_is_cmd;
    assign o_last_byte    = r_last;

endmodule

>>> rtl/radio_frame_deframer.sv
// Radio frame deframer top level: controller and datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | in        | i_in_valid / o_in_stall  | i_rx_byte
//  out     | out       | o_out_valid / i_out_stall| o_payload_byte, o_is_command, o_last_byte
//  cfg     | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One received word per cycle while hunting, matching the header or collecting the body.
// A good frame of length L then drains L-1 words, one per cycle at best, out of the
// single-port body store; input is stalled until the last word is read out.
// The output register lets the last word wait while the next header is taken.
// Synchronous active-low reset; the body store itself is not cleared.
module radio_frame_deframer
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_is_command,
    output logic        o_last_byte
);

    t_cmd    w_cmd;
    t_status w_status;

    rfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rfd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_is_command   (o_is_command),
        .o_last_byte    (o_last_byte)
    );

endmodule

>>> rtl/rfd_checker.sv
// Port-level checker for the frame deframer and its bind to the top level.
module rfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_payload_byte,
    input logic       o_is_command,
    input logic       o_last_byte
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte))
        else $error("stalled output word changed or dropped");

    // a run never ends between words: more words follow or the drain is still going
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte |=> o_out_valid || o_in_stall)
        else $error("run stopped before its last word");

    // only the first word of a run is marked as command
    a_cmd_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte |=> !(o_out_valid && o_is_command))
        else $error("command mark inside a run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stalled after reset");

endmodule

bind radio_frame_deframer rfd_checker u_rfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_payload_byte (o_payload_byte),
    .o_is_command   (o_is_command),
    .o_last_byte    (o_last_byte)
);
